// ===== design/lfd_pkg.sv =====
// Package for the length field deframer: shared constants, codes and the
// front-to-back command type. No dependencies.
`default_nettype none
package lfd_pkg;
    localparam int MAX_PACKET    = 8192;
    localparam int HEADER_WINDOW = 32;
    localparam int FIELD_MAX     = 16;
    localparam int LEN_W         = 14;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_WIDTH = 3'd1;
    localparam logic [2:0] ERR_ZERO  = 3'd2;
    localparam logic [2:0] ERR_LONG  = 3'd3;
    localparam logic [2:0] ERR_SHORT = 3'd4;

    localparam logic [2:0] CFG_OFFSET = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_KIND   = 3'd2;
    localparam logic [2:0] CFG_HASHDR = 3'd3;
    localparam logic [2:0] CFG_HDRLEN = 3'd4;

    localparam logic [1:0] KIND_BIN  = 2'd0;
    localparam logic [1:0] KIND_DEC  = 2'd1;
    localparam logic [1:0] KIND_HEX  = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    localparam logic [2:0] TP_BLANK  = 3'd0;
    localparam logic [2:0] TP_PLUS   = 3'd1;
    localparam logic [2:0] TP_MINUS  = 3'd2;
    localparam logic [2:0] TP_ZERO   = 3'd3;
    localparam logic [2:0] TP_ZERON  = 3'd4;
    localparam logic [2:0] TP_DIG    = 3'd5;
    localparam logic [2:0] TP_DIGN   = 3'd6;
    localparam logic [2:0] TP_DONE   = 3'd7;

    // command from front to back
    typedef struct packed {
        logic       burst;   // release held bytes
        logic       err;
        logic [2:0] code;
        logic [7:0] data;
        logic       last;    // final_byte of a pass-through byte or of the burst
        logic [5:0] count;   // burst length, 1..32
    } cmd_t;
endpackage
`default_nettype wire

// ===== design/lfd_front.sv =====
// Front end: header byte counting, length field decode and classification.
// Depends on lfd_pkg; feeds commands into lfd_queue.
`default_nettype none
module lfd_front #(
    parameter int MAX_PACKET    = lfd_pkg::MAX_PACKET,
    parameter int HEADER_WINDOW = lfd_pkg::HEADER_WINDOW,
    parameter int FIELD_MAX     = lfd_pkg::FIELD_MAX,
    parameter int LW            = $clog2(MAX_PACKET + 2)
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire [7:0]         in_byte,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire [4:0]         field_offset,
    input  wire [4:0]         field_width,
    input  wire [1:0]         field_kind,
    input  wire               length_has_header,
    input  wire [13:0]        header_bytes,
    output lfd_pkg::cmd_t     cmd,
    output logic [LW-1:0]     cmd_len,
    output logic              cmd_valid,
    input  wire               cmd_ready,
    input  wire               back_busy
);
    localparam logic [LW-1:0] SAT = LW'(MAX_PACKET + 1);
    localparam int CW = LW + 1;

    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] flen_reg, flen_next, acc_reg, acc_next;
    logic          known_reg, known_next;
    logic [2:0]    tp_reg, tp_next;

    logic [5:0]  window;
    logic [CW-1:0] cnt1;
    logic        in_field, fire;
    logic [4:0]  dig;
    logic        isd, neg, blank;
    logic [4:0]  base;
    logic [LW+8:0] prod;
    logic [LW+1:0] sum;
    logic [2:0]  code;

    assign in_ready = cmd_ready && !back_busy;
    assign fire = in_valid && in_ready;
    assign window = {1'b0, field_offset} + {1'b0, field_width};
    assign cnt1 = count_reg + CW'(1);
    assign in_field = (count_reg >= CW'(field_offset)) && (count_reg < CW'(window));
    assign base = (field_kind == lfd_pkg::KIND_HEX) ? 5'd16 : 5'd10;

    always_comb begin
        if (in_byte >= "0" && in_byte <= "9") dig = 5'(in_byte - "0");
        else if (in_byte >= "a" && in_byte <= "f") dig = 5'(in_byte - "a" + 8'd10);
        else if (in_byte >= "A" && in_byte <= "F") dig = 5'(in_byte - "A" + 8'd10);
        else dig = 5'd16;
    end
    assign isd = dig < base;
    assign neg = (tp_reg == lfd_pkg::TP_MINUS) || (tp_reg == lfd_pkg::TP_ZERON) ||
                 (tp_reg == lfd_pkg::TP_DIGN);
    assign blank = (in_byte == 8'd32) || (in_byte >= 8'd9 && in_byte <= 8'd13);

    always_comb begin
        prod = (field_kind == lfd_pkg::KIND_BIN) ? {acc_reg, 8'd0} + (LW+9)'(in_byte)
             : (LW+9)'(acc_reg) * (LW+9)'(base) + (LW+9)'(dig);
    end

    always_comb begin
        acc_next = acc_reg;
        tp_next  = tp_reg;
        if (field_kind == lfd_pkg::KIND_BIN) begin
            acc_next = (prod > (LW+9)'(SAT)) ? SAT : prod[LW-1:0];
        end else if (field_kind != lfd_pkg::KIND_RSVD) begin
            case (tp_reg)
                lfd_pkg::TP_BLANK, lfd_pkg::TP_PLUS, lfd_pkg::TP_MINUS: begin
                    if (tp_reg == lfd_pkg::TP_BLANK && blank) begin
                    end else if (tp_reg == lfd_pkg::TP_BLANK && in_byte == "+") begin
                        tp_next = lfd_pkg::TP_PLUS;
                    end else if (tp_reg == lfd_pkg::TP_BLANK && in_byte == "-") begin
                        tp_next = lfd_pkg::TP_MINUS;
                    end else if (!isd) begin
                        tp_next = lfd_pkg::TP_DONE;
                    end else if (dig == 5'd0) begin
                        tp_next = neg ? lfd_pkg::TP_ZERON : lfd_pkg::TP_ZERO;
                    end else begin
                        acc_next = neg ? SAT : LW'(dig);
                        tp_next  = neg ? lfd_pkg::TP_DIGN : lfd_pkg::TP_DIG;
                    end
                end
                lfd_pkg::TP_ZERO, lfd_pkg::TP_ZERON, lfd_pkg::TP_DIG,
                lfd_pkg::TP_DIGN: begin
                    if ((tp_reg == lfd_pkg::TP_ZERO || tp_reg == lfd_pkg::TP_ZERON)
                        && base == 5'd16 && (in_byte == "x" || in_byte == "X")) begin
                        tp_next = neg ? lfd_pkg::TP_DIGN : lfd_pkg::TP_DIG;
                    end else if (!isd) begin
                        tp_next = lfd_pkg::TP_DONE;
                    end else begin
                        tp_next = neg ? lfd_pkg::TP_DIGN : lfd_pkg::TP_DIG;
                        if (neg) acc_next = (acc_reg != '0 || dig != 5'd0) ? SAT : '0;
                        else acc_next = (prod > (LW+9)'(SAT)) ? SAT : prod[LW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    logic [LW-1:0] acc_fin;
    assign acc_fin = in_field ? acc_next : acc_reg;
    assign sum = (LW+2)'(acc_fin) + (LW+2)'(header_bytes);

    logic [LW-1:0] len_tot;
    always_comb begin
        len_tot = acc_fin;
        if (!length_has_header) len_tot = (sum > (LW+2)'(SAT)) ? SAT : sum[LW-1:0];
        if (field_kind == lfd_pkg::KIND_RSVD || field_width > 5'(FIELD_MAX) ||
            cnt1 > CW'(HEADER_WINDOW) ||
            (field_kind == lfd_pkg::KIND_BIN && field_width != 5'd1 &&
             field_width != 5'd2 && field_width != 5'd4))
            code = lfd_pkg::ERR_WIDTH;
        else if (acc_fin == '0) code = lfd_pkg::ERR_ZERO;
        else if (len_tot > LW'(MAX_PACKET)) code = lfd_pkg::ERR_LONG;
        else if (CW'(len_tot) < cnt1) code = lfd_pkg::ERR_SHORT;
        else code = lfd_pkg::ERR_NONE;
    end

    always_comb begin
        count_next = count_reg;
        flen_next  = flen_reg;
        known_next = known_reg;
        cmd        = '0;
        cmd.data   = in_byte;
        cmd_len    = flen_reg;
        cmd_valid  = 1'b0;
        if (fire) begin
            if (known_reg) begin
                cmd_valid = 1'b1;
                cmd.last  = CW'(flen_reg) <= cnt1;
                count_next = cnt1;
                if (cmd.last) begin
                    count_next = '0;
                    known_next = 1'b0;
                    flen_next  = '0;
                end
            end else begin
                count_next = cnt1;
                if (cnt1 >= CW'(window)) begin
                    cmd_valid = 1'b1;
                    count_next = '0;
                    if (code != lfd_pkg::ERR_NONE) begin
                        cmd.err  = 1'b1;
                        cmd.code = code;
                    end else begin
                        cmd.burst = 1'b1;
                        cmd.count = 6'(cnt1);
                        cmd.last  = CW'(len_tot) == cnt1;
                        cmd_len   = len_tot;
                        if (!cmd.last) begin
                            known_next = 1'b1;
                            flen_next  = len_tot;
                            count_next = cnt1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            flen_reg  <= '0;
            known_reg <= 1'b0;
            acc_reg   <= '0;
            tp_reg    <= lfd_pkg::TP_BLANK;
        end else if (fire) begin
            count_reg <= count_next;
            flen_reg  <= flen_next;
            known_reg <= known_next;
            if (cmd_valid) begin
                acc_reg <= '0;
                tp_reg  <= lfd_pkg::TP_BLANK;
            end else if (!known_reg && in_field) begin
                acc_reg <= acc_next;
                tp_reg  <= tp_next;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/lfd_queue.sv =====
// Short command queue between front and back. Depends on lfd_pkg.
`default_nettype none
module lfd_queue #(
    parameter int LW = 14
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  lfd_pkg::cmd_t    wr_cmd,
    input  wire [LW-1:0]     wr_len,
    input  wire              wr_valid,
    output logic             wr_ready,
    output lfd_pkg::cmd_t    rd_cmd,
    output logic [LW-1:0]    rd_len,
    output logic             rd_valid,
    input  wire              rd_ready
);
    lfd_pkg::cmd_t mem_cmd [4];
    logic [LW-1:0] mem_len [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] n_reg;
    logic wr, rd;

    assign wr_ready = n_reg < 3'd4;
    assign rd_valid = n_reg != 3'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_cmd = mem_cmd[rp_reg];
    assign rd_len = mem_len[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_cmd[wp_reg] <= wr_cmd;
            mem_len[wp_reg] <= wr_len;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg  <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            n_reg <= n_reg + 3'(wr) - 3'(rd);
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= 3'd4) else $error("queue overflow");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> n_reg == $past(n_reg) + 3'd1) else $error("queue count");
    a_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid == (n_reg != 0)) else $error("queue valid");
endmodule
`default_nettype wire

// ===== design/lfd_back.sv =====
// Back end: header store, burst release and output register.
// Depends on lfd_pkg; reads commands from lfd_queue.
`default_nettype none
module lfd_back #(
    parameter int LW            = 14,
    parameter int HEADER_WINDOW = lfd_pkg::HEADER_WINDOW,
    parameter int HW            = $clog2(HEADER_WINDOW)
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              st_we,
    input  wire [HW-1:0]     st_addr,
    input  wire [7:0]        st_data,
    input  lfd_pkg::cmd_t    cmd,
    input  wire [LW-1:0]     cmd_len,
    input  wire              cmd_valid,
    output logic             cmd_ready,
    output logic             busy,
    output logic [7:0]       m_out_byte,
    output logic             m_first_byte,
    output logic             m_final_byte,
    output logic [13:0]      m_packet_len,
    output logic             m_error_flag,
    output logic [2:0]       m_error_code,
    output logic             m_run_end,
    output logic             m_valid,
    input  wire              m_ready
);
    logic [7:0] store [HEADER_WINDOW];
    logic [6:0] idx_reg;
    logic       act_reg;
    lfd_pkg::cmd_t cur_reg;
    logic [LW-1:0] len_reg;
    logic       adv, lastb;

    always_ff @(posedge aclk) begin
        if (st_we) store[st_addr] <= st_data;
    end

    assign adv = !m_valid || m_ready;
    assign lastb = act_reg && (idx_reg + 7'd1 == {1'b0, cur_reg.count});
    assign cmd_ready = adv && !act_reg;
    assign busy = act_reg || cmd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
            act_reg <= 1'b0;
            idx_reg <= '0;
        end else if (adv) begin
            m_valid <= 1'b0;
            if (act_reg) begin
                m_valid      <= 1'b1;
                m_out_byte   <= store[idx_reg[HW-1:0]];
                m_first_byte <= idx_reg == '0;
                m_final_byte <= lastb && cur_reg.last;
                m_packet_len <= 14'(len_reg);
                m_error_flag <= 1'b0;
                m_error_code <= lfd_pkg::ERR_NONE;
                m_run_end    <= lastb;
                idx_reg      <= idx_reg + 7'd1;
                if (lastb) act_reg <= 1'b0;
            end else if (cmd_valid) begin
                if (cmd.burst) begin
                    act_reg <= 1'b1;
                    cur_reg <= cmd;
                    len_reg <= cmd_len;
                    idx_reg <= '0;
                end else begin
                    m_valid      <= 1'b1;
                    m_out_byte   <= cmd.err ? 8'd0 : cmd.data;
                    m_first_byte <= 1'b0;
                    m_final_byte <= cmd.last;
                    m_packet_len <= cmd.err ? 14'd0 : 14'(cmd_len);
                    m_error_flag <= cmd.err;
                    m_error_code <= cmd.code;
                    m_run_end    <= 1'b1;
                end
            end
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_flag) |-> m_run_end) else $error("error not run end");
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_first_byte) |-> !m_error_flag) else $error("bad first");
endmodule
`default_nettype wire

// ===== design/length_field_deframer.sv =====
// Top level of the length field deframer: config registers, front, queue, back.
// Depends on lfd_pkg, lfd_front, lfd_queue and lfd_back.
//
// Usage: bytes enter on s_data_byte with s_valid/s_ready; results leave on the
// m_ ports with m_valid/m_ready; registers are written on cfg_valid/cfg_ready
// with cfg_index and cfg_data while the block is idle.
// Each accepted byte past the header yields one result, written first into
// the queue, then into the back output register; input waits for the queue
// and back end to drain, so no byte is taken until the last has left the queue.
// When the length field completes, the held header of N bytes is released
// from the header store one per cycle while the receiver does not stall; input
// is held off during that release, as the back end reads one entry per cycle.
// A bad length gives one error result and the search restarts at the next
// byte. Reset clears all control state and sets registers to their defaults.
// When the receiver stalls, the output register holds, the command queue
// keeps its one pending command and s_ready stays low; nothing is lost.
`default_nettype none
module length_field_deframer #(
    parameter int MAX_PACKET    = lfd_pkg::MAX_PACKET,
    parameter int HEADER_WINDOW = lfd_pkg::HEADER_WINDOW,
    parameter int FIELD_MAX     = lfd_pkg::FIELD_MAX
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire [7:0]   s_data_byte,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire [2:0]   cfg_index,
    input  wire [13:0]  cfg_data,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_first_byte,
    output logic        m_final_byte,
    output logic [13:0] m_packet_len,
    output logic        m_error_flag,
    output logic [2:0]  m_error_code,
    output logic        m_run_end,
    output logic        m_valid,
    input  wire         m_ready
);
    localparam int LW = $clog2(MAX_PACKET + 2);
    localparam int HW = $clog2(HEADER_WINDOW);

    logic [4:0]  off_reg, wid_reg;
    logic [1:0]  kind_reg;
    logic        hh_reg;
    logic [13:0] hb_reg;
    logic [HW:0] wp_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg  <= 5'd0;
            wid_reg  <= 5'd4;
            kind_reg <= lfd_pkg::KIND_BIN;
            hh_reg   <= 1'b1;
            hb_reg   <= 14'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                lfd_pkg::CFG_OFFSET: off_reg  <= cfg_data[4:0];
                lfd_pkg::CFG_WIDTH:  wid_reg  <= cfg_data[4:0];
                lfd_pkg::CFG_KIND:   kind_reg <= cfg_data[1:0];
                lfd_pkg::CFG_HASHDR: hh_reg   <= cfg_data[0];
                lfd_pkg::CFG_HDRLEN: hb_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    lfd_pkg::cmd_t f_cmd, q_cmd;
    logic [LW-1:0] f_len, q_len;
    logic f_valid, f_ready, q_valid, q_ready, b_busy, fire, known_pos;

    lfd_front #(.MAX_PACKET(MAX_PACKET), .HEADER_WINDOW(HEADER_WINDOW),
                .FIELD_MAX(FIELD_MAX), .LW(LW)) u_front (
        .aclk, .aresetn, .in_byte(s_data_byte), .in_valid(s_valid), .in_ready(s_ready),
        .field_offset(off_reg), .field_width(wid_reg), .field_kind(kind_reg),
        .length_has_header(hh_reg), .header_bytes(hb_reg),
        .cmd(f_cmd), .cmd_len(f_len), .cmd_valid(f_valid), .cmd_ready(f_ready),
        .back_busy(b_busy));

    lfd_queue #(.LW(LW)) u_queue (
        .aclk, .aresetn, .wr_cmd(f_cmd), .wr_len(f_len), .wr_valid(f_valid),
        .wr_ready(f_ready), .rd_cmd(q_cmd), .rd_len(q_len), .rd_valid(q_valid),
        .rd_ready(q_ready));

    // header write pointer tracks header bytes; a burst with payload to follow parks it, others reset it
    assign fire = s_valid && s_ready;
    assign known_pos = wp_reg == '1;
    always_ff @(posedge aclk) begin
        if (!aresetn) wp_reg <= '0;
        else if (fire && f_valid) wp_reg <= (f_cmd.burst && !f_cmd.last) ? '1 : '0;
        else if (fire && f_valid == 1'b0 && !known_pos) wp_reg <= wp_reg + (HW+1)'(1);
    end

    lfd_back #(.LW(LW), .HEADER_WINDOW(HEADER_WINDOW), .HW(HW)) u_back (
        .aclk, .aresetn,
        .st_we(fire && !known_pos && !wp_reg[HW]), .st_addr(wp_reg[HW-1:0]),
        .st_data(s_data_byte),
        .cmd(q_cmd), .cmd_len(q_len), .cmd_valid(q_valid), .cmd_ready(q_ready),
        .busy(b_busy),
        .m_out_byte, .m_first_byte, .m_final_byte, .m_packet_len, .m_error_flag,
        .m_error_code, .m_run_end, .m_valid, .m_ready);
endmodule
`default_nettype wire

// ===== tb/length_field_deframer_test.sv =====
// Self-checking testbench for length_field_deframer: directed table, then random
// framed streams over several register settings, checked by a local predictor.
// Depends on lfd_pkg and the length_field_deframer RTL.
`default_nettype none
module length_field_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  ob;
        logic        first;
        logic        fin;
        logic [13:0] len;
        logic        err;
        logic [2:0]  code;
        logic        run_end;
    } beat_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        beat_t      exp;
    } row_t;

    typedef struct {
        int off;
        int w;
        int kind;
        int hh;
        int hb;
        int npk;
    } setting_t;

    localparam int SAT_LEN = lfd_pkg::MAX_PACKET + 1;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic [7:0]  s_data_byte = 0;
    logic        s_valid = 0;
    wire         s_ready;
    logic [2:0]  cfg_index = 0;
    logic [13:0] cfg_data = 0;
    logic        cfg_valid = 0;
    wire         cfg_ready;
    wire [7:0]   m_out_byte;
    wire         m_first_byte, m_final_byte, m_error_flag, m_run_end, m_valid;
    wire [13:0]  m_packet_len;
    wire [2:0]   m_error_code;
    logic        m_ready = 0;

    length_field_deframer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_data_byte(s_data_byte), .s_valid(s_valid), .s_ready(s_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .m_out_byte(m_out_byte), .m_first_byte(m_first_byte),
        .m_final_byte(m_final_byte), .m_packet_len(m_packet_len),
        .m_error_flag(m_error_flag), .m_error_code(m_error_code),
        .m_run_end(m_run_end), .m_valid(m_valid), .m_ready(m_ready)
    );

    always #1 aclk = ~aclk;

    // predictor copy of registers and framing state
    logic [4:0]  r_offset;
    logic [4:0]  r_width;
    logic [1:0]  r_kind;
    logic        r_hashdr;
    logic [13:0] r_hdrlen;
    logic [13:0] byte_count;
    logic [13:0] frame_length;
    logic        length_known;
    logic [13:0] length_accum;
    logic [2:0]  text_phase;
    logic [7:0]  held_hdr [lfd_pkg::HEADER_WINDOW];

    beat_t frame_beats [$];
    beat_t step_beats [$];
    int    n_fail = 0;
    int    n_bytes = 0;
    int    n_results = 0;
    int    n_errs = 0;
    int    n_cfg = 0;
    bit    no_idle = 0;
    int    quiet = 0;

    function automatic void restart_search();
        byte_count = 0;
        frame_length = 0;
        length_known = 0;
        length_accum = 0;
        text_phase = lfd_pkg::TP_BLANK;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic void feed_text(logic [7:0] c, int base);
        int  d;
        bit  isd, neg;
        int  v;
        d = hex_digit(c);
        isd = d < base;
        neg = (text_phase == lfd_pkg::TP_MINUS || text_phase == lfd_pkg::TP_ZERON ||
               text_phase == lfd_pkg::TP_DIGN);
        if (text_phase == lfd_pkg::TP_BLANK) begin
            if (c == " " || (c >= 9 && c <= 13)) return;
            if (c == "+") begin text_phase = lfd_pkg::TP_PLUS; return; end
            if (c == "-") begin text_phase = lfd_pkg::TP_MINUS; return; end
        end
        if (text_phase inside {lfd_pkg::TP_BLANK, lfd_pkg::TP_PLUS, lfd_pkg::TP_MINUS}) begin
            if (!isd) begin text_phase = lfd_pkg::TP_DONE; return; end
            if (d == 0) begin
                text_phase = neg ? lfd_pkg::TP_ZERON : lfd_pkg::TP_ZERO;
                return;
            end
            length_accum = neg ? 14'(SAT_LEN) : 14'(d);
            text_phase = neg ? lfd_pkg::TP_DIGN : lfd_pkg::TP_DIG;
            return;
        end
        if (text_phase == lfd_pkg::TP_ZERO || text_phase == lfd_pkg::TP_ZERON) begin
            text_phase = neg ? lfd_pkg::TP_DIGN : lfd_pkg::TP_DIG;
            if (base == 16 && (c == "x" || c == "X")) return;
        end
        if (text_phase == lfd_pkg::TP_DIG || text_phase == lfd_pkg::TP_DIGN) begin
            if (!isd) begin text_phase = lfd_pkg::TP_DONE; return; end
            if (neg) begin
                length_accum = (length_accum != 0 || d != 0) ? 14'(SAT_LEN) : 14'd0;
            end else begin
                v = length_accum * base + d;
                length_accum = v > SAT_LEN ? 14'(SAT_LEN) : 14'(v);
            end
        end
    endfunction

    function automatic beat_t mk(logic [7:0] ob, logic first, logic fin, logic [13:0] len,
                                 logic err, logic [2:0] code, logic run_end);
        beat_t t;
        t.ob = ob; t.first = first; t.fin = fin; t.len = len;
        t.err = err; t.code = code; t.run_end = run_end;
        return t;
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        int window, idx, cnt, len, v;
        logic [2:0] code;
        step_beats.delete();
        window = r_offset + r_width;
        code = lfd_pkg::ERR_NONE;
        if (length_known) begin
            byte_count++;
            if (byte_count >= frame_length) begin
                step_beats.push_back(mk(b, 0, 1, frame_length, 0, lfd_pkg::ERR_NONE, 1));
                restart_search();
            end else begin
                step_beats.push_back(mk(b, 0, 0, frame_length, 0, lfd_pkg::ERR_NONE, 1));
            end
            return;
        end
        idx = byte_count;
        if (idx < lfd_pkg::HEADER_WINDOW) held_hdr[idx] = b;
        if (idx >= r_offset && idx < window) begin
            if (r_kind == lfd_pkg::KIND_BIN) begin
                v = length_accum * 256 + b;
                length_accum = v > SAT_LEN ? 14'(SAT_LEN) : 14'(v);
            end else if (r_kind == lfd_pkg::KIND_DEC) begin
                feed_text(b, 10);
            end else if (r_kind == lfd_pkg::KIND_HEX) begin
                feed_text(b, 16);
            end
        end
        cnt = idx + 1;
        byte_count = 14'(cnt);
        if (cnt < window) return;
        len = length_accum;
        if (!(r_kind inside {lfd_pkg::KIND_BIN, lfd_pkg::KIND_DEC, lfd_pkg::KIND_HEX}) ||
            r_width > lfd_pkg::FIELD_MAX || cnt > lfd_pkg::HEADER_WINDOW ||
            (r_kind == lfd_pkg::KIND_BIN && r_width != 1 && r_width != 2 && r_width != 4))
        begin
            code = lfd_pkg::ERR_WIDTH;
        end else if (len == 0) begin
            code = lfd_pkg::ERR_ZERO;
        end else begin
            if (!r_hashdr) begin
                len += r_hdrlen;
                if (len > SAT_LEN) len = SAT_LEN;
            end
            if (len > lfd_pkg::MAX_PACKET) code = lfd_pkg::ERR_LONG;
            else if (len < cnt) code = lfd_pkg::ERR_SHORT;
        end
        if (code != lfd_pkg::ERR_NONE) begin
            step_beats.push_back(mk(0, 0, 0, 0, 1, code, 1));
            restart_search();
            return;
        end
        for (int i = 0; i < cnt; i++)
            step_beats.push_back(mk(held_hdr[i], i == 0, (i + 1 == cnt) && len == cnt,
                                    14'(len), 0, lfd_pkg::ERR_NONE, i + 1 == cnt));
        if (len == cnt) begin
            restart_search();
        end else begin
            length_known = 1;
            frame_length = 14'(len);
        end
    endfunction

    task automatic report_mismatch(string what, beat_t got, beat_t want);
        n_fail++;
        $display({"mismatch %s: got ob=%02h f=%0b l=%0b len=%0d e=%0b c=%0d end=%0b",
                  " want ob=%02h f=%0b l=%0b len=%0d e=%0b c=%0d end=%0b"},
                 what, got.ob, got.first, got.fin, got.len, got.err, got.code, got.run_end,
                 want.ob, want.first, want.fin, want.len, want.err, want.code, want.run_end);
    endtask

    // result side: random stall per transfer, compare against the oldest expectation
    initial begin : result_sink
        int    stall;
        beat_t got, want;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!(m_valid && aresetn));
            got = mk(m_out_byte, m_first_byte, m_final_byte, m_packet_len,
                     m_error_flag, m_error_code, m_run_end);
            n_results++;
            if (got.err) n_errs++;
            if (frame_beats.size() == 0) begin
                report_mismatch("unexpected", got, got);
            end else begin
                want = frame_beats.pop_front();
                if (got != want) report_mismatch("field", got, want);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     quiet, frame_beats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, bit typed, beat_t lit);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        n_bytes++;
        deframe_byte(b);
        if (typed) frame_beats.push_back(lit);
        else foreach (step_beats[i]) frame_beats.push_back(step_beats[i]);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        s_valid <= 0;
        wait (frame_beats.size() == 0);
        repeat (80) @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= 14'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        n_cfg++;
        case (idx)
            lfd_pkg::CFG_OFFSET: r_offset = 5'(val);
            lfd_pkg::CFG_WIDTH:  r_width = 5'(val);
            lfd_pkg::CFG_KIND:   r_kind = 2'(val);
            lfd_pkg::CFG_HASHDR: r_hashdr = 1'(val);
            lfd_pkg::CFG_HDRLEN: r_hdrlen = 14'(val);
            default: ;
        endcase
    endtask

    function automatic void encode_field(int v, int w, int kind, ref logic [7:0] fld [$]);
        string s;
        logic [7:0] q [$];
        fld.delete();
        if (kind == lfd_pkg::KIND_BIN && w inside {1, 2, 4}) begin
            for (int i = w - 1; i >= 0; i--) fld.push_back(8'(v >> (8 * i)));
            return;
        end
        if (!(kind inside {lfd_pkg::KIND_DEC, lfd_pkg::KIND_HEX}) ||
            $urandom_range(0, 9) == 0) begin
            repeat (w) fld.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            q.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
        case ($urandom_range(0, 9))
            0, 1: q.push_back("+");
            2:    q.push_back("-");
            default: ;
        endcase
        if (kind == lfd_pkg::KIND_HEX && $urandom_range(0, 2) == 0) begin
            q.push_back("0");
            q.push_back($urandom_range(0, 1) ? "x" : "X");
        end
        if ($urandom_range(0, 4) == 0) q.push_back("0");
        if (kind == lfd_pkg::KIND_DEC) begin
            s = $sformatf("%0d", v);
        end else begin
            s = $sformatf("%0h", v);
            if ($urandom_range(0, 1)) s = s.toupper();
        end
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        case ($urandom_range(0, 3))
            0: q.push_back(" ");
            1: q.push_back(8'h00);
            2: q.push_back("z");
            default: q.push_back(8'($urandom));
        endcase
        while (q.size() < w) q.push_back(8'($urandom));
        for (int i = 0; i < w; i++) fld.push_back(q[i]);
    endfunction

    task automatic send_packet();
        int window, plen, v;
        logic [7:0] fld [$];
        beat_t none;
        window = r_offset + r_width;
        plen = $urandom_range(window > 0 ? window : 1, window + 24);
        if ($urandom_range(0, 5) == 0) plen = window > 0 ? window : 1;
        if (!r_hashdr && r_hdrlen >= plen) plen = r_hdrlen + $urandom_range(1, 24);
        v = r_hashdr ? plen : plen - r_hdrlen;
        if (r_kind == lfd_pkg::KIND_BIN && r_width == 1 && v > 255) v = 255;
        // a length that cannot fit is rejected at the field; send the header only
        if (plen > window + 32) plen = window;
        encode_field(v, r_width, r_kind, fld);
        for (int i = 0; i < r_offset; i++) send_byte(8'($urandom), 0, none);
        foreach (fld[i]) send_byte(fld[i], 0, none);
        for (int i = window; i < plen; i++) send_byte(8'($urandom), 0, none);
    endtask

    row_t dir_rows [] = '{
        '{8'h00, 0, '{default: 0}}, '{8'h00, 0, '{default: 0}}, '{8'h00, 0, '{default: 0}},
        '{8'h00, 1, '{8'h00, 0, 0, 14'd0, 1, lfd_pkg::ERR_ZERO, 1}},
        '{8'h00, 0, '{default: 0}}, '{8'h00, 0, '{default: 0}}, '{8'h20, 0, '{default: 0}},
        '{8'h01, 1, '{8'h00, 0, 0, 14'd0, 1, lfd_pkg::ERR_LONG, 1}},
        '{8'hFF, 0, '{default: 0}}, '{8'hFF, 0, '{default: 0}}, '{8'hFF, 0, '{default: 0}},
        '{8'hFF, 1, '{8'h00, 0, 0, 14'd0, 1, lfd_pkg::ERR_LONG, 1}},
        '{8'h00, 0, '{default: 0}}, '{8'h00, 0, '{default: 0}}, '{8'h00, 0, '{default: 0}},
        '{8'h02, 1, '{8'h00, 0, 0, 14'd0, 1, lfd_pkg::ERR_SHORT, 1}},
        '{8'h00, 0, '{default: 0}}, '{8'h00, 0, '{default: 0}}, '{8'h00, 0, '{default: 0}},
        '{8'h06, 0, '{default: 0}}, '{8'hAA, 0, '{default: 0}}, '{8'h55, 0, '{default: 0}}
    };

    setting_t settings [] = '{
        '{31, 1,  lfd_pkg::KIND_BIN,  1, 0,    1},
        '{3,  2,  lfd_pkg::KIND_BIN,  0, 5,    2},
        '{2,  5,  lfd_pkg::KIND_DEC,  0, 10,   2},
        '{0,  16, lfd_pkg::KIND_HEX,  1, 0,    1},
        '{5,  8,  lfd_pkg::KIND_HEX,  0, 0,    2},
        '{1,  3,  lfd_pkg::KIND_DEC,  1, 0,    2},
        '{0,  4,  lfd_pkg::KIND_BIN,  0, 8192, 3},
        '{0,  0,  lfd_pkg::KIND_BIN,  1, 0,    2},
        '{4,  20, lfd_pkg::KIND_DEC,  1, 0,    1},
        '{0,  2,  lfd_pkg::KIND_RSVD, 1, 0,    2},
        '{20, 16, lfd_pkg::KIND_HEX,  1, 0,    1},
        '{0,  3,  lfd_pkg::KIND_BIN,  1, 0,    2},
        '{0,  4,  lfd_pkg::KIND_BIN,  1, 0,    3}
    };

    initial begin : stimulus
        beat_t none;
        r_offset = 0; r_width = 4; r_kind = lfd_pkg::KIND_BIN; r_hashdr = 1; r_hdrlen = 0;
        for (int i = 0; i < lfd_pkg::HEADER_WINDOW; i++) held_hdr[i] = 0;
        restart_search();
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].exp);
        foreach (settings[p]) begin
            write_reg(lfd_pkg::CFG_OFFSET, settings[p].off);
            write_reg(lfd_pkg::CFG_WIDTH, settings[p].w);
            write_reg(lfd_pkg::CFG_KIND, settings[p].kind);
            write_reg(lfd_pkg::CFG_HASHDR, settings[p].hh);
            write_reg(lfd_pkg::CFG_HDRLEN, settings[p].hb);
            no_idle = (p % 4 == 3);
            repeat (settings[p].npk) begin
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 0, none);
                send_packet();
            end
        end
        s_valid <= 0;
        wait (frame_beats.size() == 0);
        repeat (100) @(posedge aclk);
        $display("covered %0d input bytes, %0d results (%0d errors), %0d register writes",
                 n_bytes, n_results, n_errs, n_cfg);
        $display("binary, decimal and hex length fields, header on and off, bad widths");
        if (n_fail == 0 && frame_beats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
